// ===== design/line_follow_pd_steering_macros.svh =====
// Assertion macros for the line follower steering block
`ifndef LINE_FOLLOW_PD_STEERING_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset
`define LFPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LFPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lfpd_pkg.sv =====
package lfpd_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_W     = 8;
    localparam int CFG_W        = 6;
    localparam int ERR_W        = 5;
    localparam int DUTY_W       = 7;
    localparam int SUM_W        = 14;

    // Request types
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_CAL   = 2'd1;
    localparam logic [1:0] REQ_RUN   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PROP_GAIN   = 2'd0;
    localparam logic [1:0] CFG_DERIV_GAIN  = 2'd1;
    localparam logic [1:0] CFG_DUTY_OFFSET = 2'd2;
    localparam logic [1:0] CFG_LEFT_BIAS   = 2'd3;

    typedef struct packed {
        logic clear;
        logic calib;
    } t_lane_ctl;

    typedef struct packed {
        logic        [CFG_W-1:0] prop;
        logic        [CFG_W-1:0] deriv;
        logic signed [CFG_W-1:0] offset;
        logic        [CFG_W-1:0] bias;
    } t_gains;

    typedef struct packed {
        logic                    known;
        logic signed [ERR_W-1:0] err;
    } t_lookup;

    // Sensor pattern to line position error
    function automatic t_lookup err_lookup(input logic [MAX_CHANNELS-1:0] pat);
        t_lookup r;
        r.known = 1'b1;
        case (pat)
            8'h01:   r.err = 5'sd15;
            8'h03:   r.err = 5'sd10;
            8'h02:   r.err = 5'sd5;
            8'h06:   r.err = 5'sd4;
            8'h04:   r.err = 5'sd3;
            8'h0C:   r.err = 5'sd2;
            8'h08:   r.err = 5'sd1;
            8'h10:   r.err = -5'sd1;
            8'h30:   r.err = -5'sd2;
            8'h20:   r.err = -5'sd3;
            8'h60:   r.err = -5'sd4;
            8'h40:   r.err = -5'sd5;
            8'hC0:   r.err = -5'sd10;
            8'h80:   r.err = -5'sd15;
            default: begin
                r.known = 1'b0;
                r.err   = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/lfpd_lane.sv =====
module lfpd_lane
    import lfpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_ctl           i_ctl,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_below
);

    logic [SAMPLE_W-1:0] r_low, r_high, r_thr;
    logic [SAMPLE_W-1:0] n_low, n_high;
    logic [SAMPLE_W:0]   w_mid_sum;

    assign n_low     = (i_sample < r_low)  ? i_sample : r_low;
    assign n_high    = (i_sample > r_high) ? i_sample : r_high;
    assign w_mid_sum = {1'b0, n_high} + {1'b0, n_low};
    assign o_below   = i_sample < r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '1;
            r_high <= '0;
            r_thr  <= '0;
        end else if (i_ctl.clear) begin
            // thresholds survive a clear
            r_low  <= '1;
            r_high <= '0;
        end else if (i_ctl.calib) begin
            r_low  <= n_low;
            r_high <= n_high;
            r_thr  <= w_mid_sum[SAMPLE_W:1];
        end
    end

endmodule

// ===== design/lfpd_merge.sv =====
module lfpd_merge
    import lfpd_pkg::*;
#(
    parameter int DUTY_MAX = 100
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [MAX_CHANNELS-1:0] i_pattern,
    input  t_gains                  i_gains,
    input  logic                    i_out_stall,
    output logic                    o_full,
    output logic                    o_valid,
    output logic [DUTY_W-1:0]       o_left_duty,
    output logic [DUTY_W-1:0]       o_right_duty,
    output logic [MAX_CHANNELS-1:0] o_line_pattern,
    output logic signed [ERR_W-1:0] o_line_error,
    output logic                    o_pattern_known
);

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] c;
        if (v < 0) begin
            c = '0;
        end else if (v > $signed(SUM_W'(DUTY_MAX))) begin
            c = SUM_W'(DUTY_MAX);
        end else begin
            c = v;
        end
        return c[DUTY_W-1:0];
    endfunction

    logic en1, en2, en3;

    // Stage 1: pattern from the lanes
    logic                    r_v1;
    logic [MAX_CHANNELS-1:0] r_pat1;

    // Stage 2: error and products
    logic                      r_v2;
    logic [MAX_CHANNELS-1:0]   r_pat2;
    logic signed [ERR_W-1:0]   r_err2;
    logic                      r_known2;
    logic signed [11:0]        r_p2;
    logic signed [12:0]        r_d2;
    logic signed [ERR_W-1:0]   r_prev;

    t_lookup                 w_lk;
    logic signed [ERR_W-1:0] w_err;
    logic signed [ERR_W:0]   w_diff;

    // Stage 3: sums and saturation
    logic signed [SUM_W-1:0] w_pd, w_right, w_left;

    assign en3    = !o_valid || !i_out_stall;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_full = !en1;

    assign w_lk   = err_lookup(r_pat1);
    assign w_err  = w_lk.known ? w_lk.err : r_prev;
    assign w_diff = (ERR_W+1)'(w_err) - (ERR_W+1)'(r_prev);

    assign w_pd    = SUM_W'(r_p2) + SUM_W'(r_d2);
    assign w_right = w_pd + SUM_W'(i_gains.offset);
    assign w_left  = w_pd - SUM_W'(i_gains.offset) + $signed({{(SUM_W-CFG_W){1'b0}}, i_gains.bias});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
            r_prev  <= '0;
        end else begin
            if (en1) r_v1 <= i_push;
            if (en2) r_v2 <= r_v1;
            if (en3) o_valid <= r_v2;
            // advance the derivative history in item order
            if (en2 && r_v1) r_prev <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_push) r_pat1 <= i_pattern;
        if (en2 && r_v1) begin
            r_pat2   <= r_pat1;
            r_err2   <= w_err;
            r_known2 <= w_lk.known;
            r_p2     <= $signed({1'b0, i_gains.prop}) * w_err;
            r_d2     <= $signed({1'b0, i_gains.deriv}) * w_diff;
        end
        if (en3 && r_v2) begin
            o_left_duty     <= clamp_duty(w_left);
            o_right_duty    <= clamp_duty(w_right);
            o_line_pattern  <= r_pat2;
            o_line_error    <= r_err2;
            o_pattern_known <= r_known2;
        end
    end

endmodule

// ===== design/line_follow_pd_steering.sv =====
// An accepted run request is registered in r_v1, then r_v2, then o_valid.
// One request per cycle while o_stall is low; clear/calib requests give no result.
// At the accepting edge, clear resets limits; calib updates limits and thresholds.
// Backpressure reaches o_stall only once all three pipeline stages hold work.
// Reset (synchronous, i_rst_n low): limits 255/0, thresholds and error history
// zero, gains back to their defaults, pipeline emptied.
module line_follow_pd_steering
    import lfpd_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int DUTY_MAX     = 100
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_req_type,
    input  logic [SAMPLE_W-1:0]     i_sample_0,
    input  logic [SAMPLE_W-1:0]     i_sample_1,
    input  logic [SAMPLE_W-1:0]     i_sample_2,
    input  logic [SAMPLE_W-1:0]     i_sample_3,
    input  logic [SAMPLE_W-1:0]     i_sample_4,
    input  logic [SAMPLE_W-1:0]     i_sample_5,
    input  logic [SAMPLE_W-1:0]     i_sample_6,
    input  logic [SAMPLE_W-1:0]     i_sample_7,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [DUTY_W-1:0]       o_left_duty,
    output logic [DUTY_W-1:0]       o_right_duty,
    output logic [MAX_CHANNELS-1:0] o_line_pattern,
    output logic signed [ERR_W-1:0] o_line_error,
    output logic                    o_pattern_known,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    `include "line_follow_pd_steering_macros.svh"

    logic                    w_accept;
    t_lane_ctl               w_ctl;
    t_gains                  r_gains;
    logic [SAMPLE_W-1:0]     w_samples [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] w_pattern;

    assign w_accept    = i_valid && !o_stall;
    assign w_ctl.clear = w_accept && (i_req_type == REQ_CLEAR);
    assign w_ctl.calib = w_accept && (i_req_type == REQ_CAL);
    assign o_cfg_ready = 1'b1;

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;
    assign w_samples[6] = i_sample_6;
    assign w_samples[7] = i_sample_7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop   <= 6'd4;
            r_gains.deriv  <= 6'd10;
            r_gains.offset <= 6'sd1;
            r_gains.bias   <= 6'd20;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:   r_gains.prop   <= i_cfg_data;
                CFG_DERIV_GAIN:  r_gains.deriv  <= i_cfg_data;
                CFG_DUTY_OFFSET: r_gains.offset <= $signed(i_cfg_data);
                CFG_LEFT_BIAS:   r_gains.bias   <= i_cfg_data;
                default:         r_gains        <= r_gains;
            endcase
        end
    end

    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
        if (c < NUM_CHANNELS) begin : g_used
            lfpd_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_sample (w_samples[c]),
                .o_below  (w_pattern[c])
            );
        end else begin : g_unused
            assign w_pattern[c] = 1'b0;
        end
    end

    lfpd_merge #(
        .DUTY_MAX (DUTY_MAX)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_accept && (i_req_type == REQ_RUN)),
        .i_pattern       (w_pattern),
        .i_gains         (r_gains),
        .i_out_stall     (i_stall),
        .o_full          (o_stall),
        .o_valid         (o_valid),
        .o_left_duty     (o_left_duty),
        .o_right_duty    (o_right_duty),
        .o_line_pattern  (o_line_pattern),
        .o_line_error    (o_line_error),
        .o_pattern_known (o_pattern_known)
    );

    `LFPD_ASSERT_NOW(a_known_err_nonzero, o_valid && o_pattern_known, o_line_error != 5'sd0, "matched pattern gave zero error")
    `LFPD_ASSERT_NOW(a_left_in_range, o_valid, 32'(o_left_duty) <= DUTY_MAX, "left duty above limit")
    `LFPD_ASSERT_NOW(a_stall_only_when_blocked, o_stall, o_valid && i_stall, "input stalled with output free")
    `LFPD_ASSERT_NEXT(a_no_result_on_empty, !o_valid && !o_stall && !i_valid, !o_valid || $past(o_stall) == 1'b0, "result without request")

endmodule
